[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// boolean condition must never be seen outside reset
`define ASSERT_NEVER_CLK(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER_CLK(lbl, clk, rstn, cond, msg)
`endif
`endif

[src/ldad_pkg.sv]
// ---------------------------------------------------------------------------
// ldad_pkg
// Types, register indexes and helpers for the launch detector and
// attitude-driven velocity command.
// ---------------------------------------------------------------------------
package ldad_pkg;

	// detector counter and time widths
	localparam int COUNT_WIDTH = 8;
	localparam int TIME_WIDTH  = 32;
	localparam int CONF_WIDTH  = 8;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > CONF_WIDTH) ? COUNT_WIDTH : CONF_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// shared multiplier geometry
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = 40;
	localparam logic [MUL_B_W-1:0] VEL_SCALE = 16'd180;
	localparam logic [PROD_W-1:0]  ROUND_HALF = 40'd16384;
	localparam int ROUND_SHIFT = 15;

	// configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] REG_AMBIENT_SQ = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BURN_SQ    = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_AMB_CONF   = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BURN_CONF  = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND   = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_VMAX       = 4'd7;

	// detector phases
	localparam logic [1:0] PH_AMBIENT  = 2'd0;
	localparam logic [1:0] PH_BURN     = 2'd1;
	localparam logic [1:0] PH_RETURN   = 2'd2;
	localparam logic [1:0] PH_LAUNCHED = 2'd3;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic               button_level;
		logic [31:0]        time_ms;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] velocity_q8;
		logic               launched;
		logic [1:0]         phase;
		logic [31:0]        launch_time_ms;
		logic signed [15:0] launch_roll;
		logic signed [15:0] launch_pitch;
		logic signed [15:0] launch_yaw;
	} result_t;

	typedef struct packed {
		logic [31:0] ambient_threshold_sq;
		logic [31:0] burn_threshold_sq;
		logic [7:0]  ambient_confirm;
		logic [7:0]  burn_confirm;
		logic [15:0] debounce_ms;
		logic [15:0] gain_q8;
		logic [14:0] deadband_counts;
		logic [14:0] max_velocity_q8;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	// detector state bundle
	typedef struct packed {
		logic [1:0]             phase;
		logic [COUNT_WIDTH-1:0] amb_cnt;
		logic [COUNT_WIDTH-1:0] burn_cnt;
		logic                   btn_prev;
		logic [TIME_WIDTH-1:0]  btn_time;
		logic [TIME_WIDTH-1:0]  cand_time;
		angles_t                cand_ang;
		logic [TIME_WIDTH-1:0]  lat_time;
		angles_t                lat_ang;
	} det_t;

	// magnitude of a raw 16-bit value; -32768 maps to 32768
	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	// saturating counter step
	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
		return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
	endfunction

endpackage

[src/launch_detect_attitude_drive.sv]
// ---------------------------------------------------------------------------
// launch_detect_attitude_drive
// Four-phase launch detector on IMU words with a pitch-driven velocity
// command, worked out on one shared multiplier under a small sequencer.
// ---------------------------------------------------------------------------
// channel   direction  handshake             word
// sample    in         sample_valid/stall    sample_t (accel, angles, button, time)
// result    out        result_valid/stall    result_t (velocity, phase, launch latch)
// cfg       in         cfg_valid/ready       cfg_index, cfg_data
//
// An IMU word passes the square, sum, detector and finish states, with the gain,
// scale and round states before finish when launched and pitch lies outside
// the deadband: the three squares and the two velocity products pass one by one
// through the single multiplier. The result register lets the next word in while
// a result waits; a word finishes only once that register is free. Reset restores
// the register defaults and the detector start state; the cfg port never stalls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module launch_detect_attitude_drive import ldad_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  sample_t                sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_SQX  = 10'b0000000010,
		ST_SQY  = 10'b0000000100,
		ST_SQZ  = 10'b0000001000,
		ST_SUM  = 10'b0000010000,
		ST_DET  = 10'b0000100000,
		ST_MULG = 10'b0001000000,
		ST_M180 = 10'b0010000000,
		ST_RND  = 10'b0100000000,
		ST_FIN  = 10'b1000000000
	} state_t;

	state_t             state_q;
	sample_t            item_q;
	cfg_t               cfg_q;
	det_t               det_q, det_d;
	logic [PROD_W-1:0]  prod_q;
	logic [31:0]        acc_q;
	logic [15:0]        mag_q;
	logic signed [15:0] vel_q;
	result_t            res_q;
	logic               res_valid_q;

	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [MUL_A_W+MUL_B_W-1:0] mul_full;
	logic [PROD_W-1:0]      mul_p;
	logic                   is_amb, is_burn;
	logic [TIME_WIDTH-1:0]  now;
	logic [15:0]            pitch_mag;
	logic [PROD_W-1:0]      rounded;
	logic [PROD_W-ROUND_SHIFT-1:0] vel_mag_w;
	logic [15:0]            vel_mag;
	logic                   res_free;

	assign sample_stall = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign res_free     = !res_valid_q || !result_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ambient_threshold_sq <= 32'd5546967;
			cfg_q.burn_threshold_sq    <= 32'd16777216;
			cfg_q.ambient_confirm      <= 8'd3;
			cfg_q.burn_confirm         <= 8'd3;
			cfg_q.debounce_ms          <= 16'd50;
			cfg_q.gain_q8              <= 16'd512;
			cfg_q.deadband_counts      <= 15'd274;
			cfg_q.max_velocity_q8      <= 15'd20480;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AMBIENT_SQ: cfg_q.ambient_threshold_sq <= cfg_data;
				REG_BURN_SQ:    cfg_q.burn_threshold_sq    <= cfg_data;
				REG_AMB_CONF:   cfg_q.ambient_confirm      <= cfg_data[7:0];
				REG_BURN_CONF:  cfg_q.burn_confirm         <= cfg_data[7:0];
				REG_DEBOUNCE:   cfg_q.debounce_ms          <= cfg_data[15:0];
				REG_GAIN:       cfg_q.gain_q8              <= cfg_data[15:0];
				REG_DEADBAND:   cfg_q.deadband_counts      <= cfg_data[14:0];
				REG_VMAX:       cfg_q.max_velocity_q8      <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = MUL_A_W'(abs16(item_q.accel_x));
				mul_b = abs16(item_q.accel_x);
			end
			ST_SQY: begin
				mul_a = MUL_A_W'(abs16(item_q.accel_y));
				mul_b = abs16(item_q.accel_y);
			end
			ST_SQZ: begin
				mul_a = MUL_A_W'(abs16(item_q.accel_z));
				mul_b = abs16(item_q.accel_z);
			end
			ST_MULG: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = cfg_q.gain_q8;
			end
			ST_M180: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = VEL_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// full-width product, then the bits the datapath keeps
	assign mul_full = mul_a * mul_b;
	assign mul_p    = mul_full[PROD_W-1:0];

	// detector update: button first, then phase logic
	assign now       = TIME_WIDTH'(item_q.time_ms);
	assign is_amb    = (acc_q <= cfg_q.ambient_threshold_sq);
	assign is_burn   = (acc_q >= cfg_q.burn_threshold_sq);
	assign pitch_mag = abs16(item_q.pitch_angle);

	always_comb begin
		det_d = det_q;
		if ((item_q.button_level != det_q.btn_prev) &&
		    ((now - det_q.btn_time) > TIME_WIDTH'(cfg_q.debounce_ms))) begin
			det_d.btn_time = now;
			det_d.btn_prev = item_q.button_level;
			if (!item_q.button_level) begin
				det_d.phase    = PH_AMBIENT;
				det_d.amb_cnt  = '0;
				det_d.burn_cnt = '0;
			end
		end
		case (det_d.phase)
			PH_AMBIENT: begin
				if (is_amb) begin
					det_d.amb_cnt = bump(det_d.amb_cnt);
					if (CMP_WIDTH'(det_d.amb_cnt) >= CMP_WIDTH'(cfg_q.ambient_confirm)) begin
						det_d.phase   = PH_BURN;
						det_d.amb_cnt = '0;
					end
				end else begin
					det_d.amb_cnt = '0;
				end
			end
			PH_BURN: begin
				if (is_burn) begin
					det_d.burn_cnt = bump(det_d.burn_cnt);
					if (CMP_WIDTH'(det_d.burn_cnt) >= CMP_WIDTH'(cfg_q.burn_confirm)) begin
						det_d.phase    = PH_RETURN;
						det_d.burn_cnt = '0;
						det_d.amb_cnt  = '0;
					end
				end else begin
					det_d.burn_cnt = '0;
				end
			end
			PH_RETURN: begin
				if (is_amb) begin
					// first ambient word of the run is the launch candidate
					if (det_d.amb_cnt == '0) begin
						det_d.cand_time      = now;
						det_d.cand_ang.roll  = item_q.roll_angle;
						det_d.cand_ang.pitch = item_q.pitch_angle;
						det_d.cand_ang.yaw   = item_q.yaw_angle;
					end
					det_d.amb_cnt = bump(det_d.amb_cnt);
					if (CMP_WIDTH'(det_d.amb_cnt) >= CMP_WIDTH'(cfg_q.ambient_confirm)) begin
						det_d.phase    = PH_LAUNCHED;
						det_d.lat_time = det_d.cand_time;
						det_d.lat_ang  = det_d.cand_ang;
					end
				end else begin
					det_d.amb_cnt = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// velocity rounding and clamp
	assign rounded   = prod_q + ROUND_HALF;
	assign vel_mag_w = rounded[PROD_W-1:ROUND_SHIFT];
	assign vel_mag   = (vel_mag_w > (PROD_W-ROUND_SHIFT)'(cfg_q.max_velocity_q8)) ?
	                   16'(cfg_q.max_velocity_q8) : vel_mag_w[15:0];

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			res_valid_q      <= 1'b0;
			det_q            <= '{btn_prev: 1'b1, default: '0};
		end else begin
			// result register: loaded by a finishing word, freed by the receiver
			if (state_q == ST_FIN && res_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample_valid && !sample_stall)
						state_q <= ST_SQX;
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					state_q <= ST_SQZ;
				end
				ST_SQZ: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DET;
				end
				ST_DET: begin
					det_q <= det_d;
					if (det_d.phase == PH_LAUNCHED &&
					    pitch_mag >= {1'b0, cfg_q.deadband_counts})
						state_q <= ST_MULG;
					else
						state_q <= ST_FIN;
				end
				ST_MULG: begin
					state_q <= ST_M180;
				end
				ST_M180: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall)
			item_q <= sample;
		case (state_q)
			ST_SQX, ST_MULG, ST_M180: begin
				prod_q <= mul_p;
			end
			ST_SQY: begin
				prod_q <= mul_p;
				acc_q  <= prod_q[31:0];
			end
			ST_SQZ: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + prod_q[31:0];
			end
			ST_SUM: begin
				acc_q <= acc_q + prod_q[31:0];
			end
			ST_DET: begin
				mag_q <= pitch_mag;
				vel_q <= '0;
			end
			ST_RND: begin
				vel_q <= item_q.pitch_angle[15] ? -$signed(vel_mag) : $signed(vel_mag);
			end
			ST_FIN: begin
				if (res_free) begin
					res_q.velocity_q8    <= vel_q;
					res_q.launched       <= (det_q.phase == PH_LAUNCHED);
					res_q.phase          <= det_q.phase;
					res_q.launch_time_ms <= 32'(det_q.lat_time);
					res_q.launch_roll    <= det_q.lat_ang.roll;
					res_q.launch_pitch   <= det_q.lat_ang.pitch;
					res_q.launch_yaw     <= det_q.lat_ang.yaw;
				end
			end
			default: begin
			end
		endcase
	end

	// checks; a press can drop the phase to await-ambient and confirm it in one step
	`ASSERT_CLK(a_launched_phase, clk, arst_n, result_valid |-> (result.launched == (result.phase == PH_LAUNCHED)), "launched flag disagrees with phase")
	`ASSERT_NEVER_CLK(a_vel_idle, clk, arst_n, result_valid && !result.launched && (result.velocity_q8 != 16'sd0), "velocity before launch")
	`ASSERT_CLK(a_phase_only_in_det, clk, arst_n, (state_q != ST_DET) |=> $stable(det_q.phase), "phase moved outside detector step")
	`ASSERT_CLK(a_phase_step, clk, arst_n, (state_q == ST_DET) |=> ((det_q.phase == $past(det_q.phase)) || (det_q.phase == $past(det_q.phase) + 2'd1) || (det_q.phase == PH_AMBIENT) || (det_q.phase == PH_BURN)), "phase skipped ahead")

endmodule

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the launch detector and pitch-driven velocity
// command. A behavioural copy of the detector predicts one result word per
// accepted IMU word. A checker compares every delivered word field by field,
// under several register settings and several patterns of idling and back
// pressure.
// ---------------------------------------------------------------------------
module tb;
	import ldad_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [31:0] THR_MAX = 32'd3221225472;
	localparam logic [CFG_INDEX_W-1:0] REG_NONE = 4'd15;

	typedef enum int {KIND_AMBIENT, KIND_BURN, KIND_NOISE} sample_kind_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	sample_t                sample = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// shadow registers and detector state of the predictor
	cfg_t                   cfg_shadow;
	logic [1:0]             ph;
	logic [COUNT_WIDTH-1:0] amb_cnt;
	logic [COUNT_WIDTH-1:0] burn_cnt;
	logic                   btn_prev;
	logic [31:0]            btn_time;
	logic [31:0]            cand_time;
	logic [31:0]            lat_time;
	angles_t                cand_ang;
	angles_t                lat_ang;

	result_t predicted_commands[$];
	int errors = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int bias_pct = 88;
	int hold_request = 0;
	int hold_left = 0;
	logic [31:0] now_ms = 32'd1000;

	launch_detect_attitude_drive u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [COUNT_WIDTH-1:0] count_up(logic [COUNT_WIDTH-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

	// proportional command with deadband, rounding half away from zero, clamp
	function automatic logic signed [15:0] pitch_velocity(logic signed [15:0] pitch);
		longint mag, prod, v;
		mag = pitch;
		if (mag < 0)
			mag = -mag;
		if (mag < longint'(cfg_shadow.deadband_counts))
			return '0;
		prod = longint'(cfg_shadow.gain_q8) * mag * 180;
		v = (prod + 16384) >>> 15;
		if (v > longint'(cfg_shadow.max_velocity_q8))
			v = longint'(cfg_shadow.max_velocity_q8);
		if (pitch < 0)
			v = -v;
		return 16'(v);
	endfunction

	function automatic result_t step_detector(sample_t s);
		longint ax, ay, az, sumsq;
		logic [31:0] dt;
		logic is_amb, is_burn;
		result_t r;
		ax = s.accel_x;
		ay = s.accel_y;
		az = s.accel_z;
		sumsq = ax * ax + ay * ay + az * az;
		is_amb = sumsq <= longint'(cfg_shadow.ambient_threshold_sq);
		is_burn = sumsq >= longint'(cfg_shadow.burn_threshold_sq);

		// debounced button; a press restarts detection
		dt = s.time_ms - btn_time;
		if (s.button_level != btn_prev && dt > 32'(cfg_shadow.debounce_ms)) begin
			btn_time = s.time_ms;
			btn_prev = s.button_level;
			if (!s.button_level) begin
				ph = PH_AMBIENT;
				amb_cnt = '0;
				burn_cnt = '0;
			end
		end

		case (ph)
			PH_AMBIENT: begin
				if (is_amb) begin
					amb_cnt = count_up(amb_cnt);
					if (amb_cnt >= cfg_shadow.ambient_confirm) begin
						ph = PH_BURN;
						amb_cnt = '0;
					end
				end else begin
					amb_cnt = '0;
				end
			end
			PH_BURN: begin
				if (is_burn) begin
					burn_cnt = count_up(burn_cnt);
					if (burn_cnt >= cfg_shadow.burn_confirm) begin
						ph = PH_RETURN;
						burn_cnt = '0;
						amb_cnt = '0;
					end
				end else begin
					burn_cnt = '0;
				end
			end
			PH_RETURN: begin
				if (is_amb) begin
					// first ambient word of the run is the launch candidate
					if (amb_cnt == '0) begin
						cand_time = s.time_ms;
						cand_ang.roll = s.roll_angle;
						cand_ang.pitch = s.pitch_angle;
						cand_ang.yaw = s.yaw_angle;
					end
					amb_cnt = count_up(amb_cnt);
					if (amb_cnt >= cfg_shadow.ambient_confirm) begin
						ph = PH_LAUNCHED;
						lat_time = cand_time;
						lat_ang = cand_ang;
					end
				end else begin
					amb_cnt = '0;
				end
			end
			default: begin
			end
		endcase

		r.velocity_q8 = (ph == PH_LAUNCHED) ? pitch_velocity(s.pitch_angle) : '0;
		r.launched = (ph == PH_LAUNCHED);
		r.phase = ph;
		r.launch_time_ms = lat_time;
		r.launch_roll = lat_ang.roll;
		r.launch_pitch = lat_ang.pitch;
		r.launch_yaw = lat_ang.yaw;
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
		case (idx)
			REG_AMBIENT_SQ: cfg_shadow.ambient_threshold_sq = data;
			REG_BURN_SQ:    cfg_shadow.burn_threshold_sq = data;
			REG_AMB_CONF:   cfg_shadow.ambient_confirm = data[7:0];
			REG_BURN_CONF:  cfg_shadow.burn_confirm = data[7:0];
			REG_DEBOUNCE:   cfg_shadow.debounce_ms = data[15:0];
			REG_GAIN:       cfg_shadow.gain_q8 = data[15:0];
			REG_DEADBAND:   cfg_shadow.deadband_counts = data[14:0];
			REG_VMAX:       cfg_shadow.max_velocity_q8 = data[14:0];
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Checker
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_commands.size() == 0) begin
				$error("result word delivered with none expected");
				errors++;
			end else begin
				want = predicted_commands.pop_front();
				check_field("velocity_q8", want.velocity_q8, result.velocity_q8);
				check_field("launched", want.launched, result.launched);
				check_field("phase", want.phase, result.phase);
				check_field("launch_time_ms", want.launch_time_ms, result.launch_time_ms);
				check_field("launch_roll", want.launch_roll, result.launch_roll);
				check_field("launch_pitch", want.launch_pitch, result.launch_pitch);
				check_field("launch_yaw", want.launch_yaw, result.launch_yaw);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic int isqrt(longint x);
		int lo, hi, mid;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (longint'(mid) * mid <= x)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// acceleration that is ambient, burn or anything under the current thresholds
	function automatic void fill_accel(inout sample_t s, input sample_kind_e kind);
		int comp[3];
		int b, lo, i;
		case (kind)
			KIND_AMBIENT: begin
				b = isqrt(longint'(cfg_shadow.ambient_threshold_sq) / 3);
				for (i = 0; i < 3; i++) begin
					comp[i] = int'($urandom_range(2 * b)) - b;
					if (comp[i] > 32767)
						comp[i] = 32767;
				end
			end
			KIND_BURN: begin
				lo = isqrt(longint'(cfg_shadow.burn_threshold_sq) / 3) + 1;
				for (i = 0; i < 3; i++) begin
					if (lo > 32767) begin
						comp[i] = -32768;
					end else begin
						comp[i] = int'($urandom_range(32767, lo));
						if ($urandom_range(1))
							comp[i] = -comp[i];
					end
				end
			end
			default: begin
				for (i = 0; i < 3; i++)
					comp[i] = int'($urandom_range(65535)) - 32768;
			end
		endcase
		s.accel_x = 16'(comp[0]);
		s.accel_y = 16'(comp[1]);
		s.accel_z = 16'(comp[2]);
	endfunction

	// next IMU word, mostly the kind the detector is waiting for
	function automatic sample_t next_sample();
		sample_t s;
		sample_kind_e wanted;
		int r, p, press_pct;
		s = '0;
		case (ph)
			PH_BURN: wanted = KIND_BURN;
			PH_LAUNCHED: wanted = ($urandom_range(99) < 70) ? KIND_AMBIENT : KIND_NOISE;
			default: wanted = KIND_AMBIENT;
		endcase
		if ($urandom_range(99) >= bias_pct)
			wanted = sample_kind_e'($urandom_range(2));
		fill_accel(s, wanted);
		s.roll_angle = 16'($urandom);
		s.yaw_angle = 16'($urandom);

		// pitch: anywhere, around the deadband edge, at the extremes, or small
		r = $urandom_range(99);
		if (r < 45) begin
			p = int'($urandom_range(65535)) - 32768;
		end else if (r < 75) begin
			p = int'(cfg_shadow.deadband_counts) + int'($urandom_range(4)) - 2;
			if ($urandom_range(1))
				p = -p;
		end else if (r < 85) begin
			p = $urandom_range(1) ? 32767 : -32768;
		end else begin
			p = int'($urandom_range(600)) - 300;
		end
		if (p > 32767)
			p = 32767;
		if (p < -32768)
			p = -32768;
		s.pitch_angle = 16'(p);

		// time: small steps, now and then a long one or an arbitrary jump
		r = $urandom_range(99);
		if (r < 4)
			now_ms = $urandom;
		else if (r < 10)
			now_ms += $urandom_range(70000, 100);
		else
			now_ms += $urandom_range(40);
		s.time_ms = now_ms;

		press_pct = (ph == PH_LAUNCHED) ? 7 : ((bias_pct == 100) ? 0 : 2);
		s.button_level = ($urandom_range(99) < press_pct) ? 1'b0 : 1'b1;
		return s;
	endfunction

	function automatic sample_t mk_sample(int ax, int ay, int az, int roll, int pitch,
			int yaw, logic btn, logic [31:0] t);
		sample_t s;
		s.accel_x = 16'(ax);
		s.accel_y = 16'(ay);
		s.accel_z = 16'(az);
		s.roll_angle = 16'(roll);
		s.pitch_angle = 16'(pitch);
		s.yaw_angle = 16'(yaw);
		s.button_level = btn;
		s.time_ms = t;
		return s;
	endfunction

	// offer one word, with an optional random gap before it
	task automatic offer_sample(input sample_t w);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= w;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		predicted_commands.push_back(step_detector(w));
	endtask

	task automatic run_flights(input int n);
		repeat (n) offer_sample(next_sample());
	endtask

	// stop offering and let every outstanding word drain
	task automatic quiesce();
		sample_valid <= 1'b0;
		while (predicted_commands.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_threshold();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 32'd0;
		if (r < 30)
			return THR_MAX;
		if (r < 70)
			return $urandom_range(40000000, 1000000);
		return $urandom_range(THR_MAX);
	endfunction

	function automatic logic [31:0] pick_confirm();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 32'd0;
		if (r < 85)
			return $urandom_range(6, 1);
		return $urandom_range(12, 7);
	endfunction

	task automatic shuffle_config();
		int r;
		write_reg(REG_AMBIENT_SQ, pick_threshold());
		write_reg(REG_BURN_SQ, pick_threshold());
		write_reg(REG_AMB_CONF, pick_confirm());
		write_reg(REG_BURN_CONF, pick_confirm());
		r = $urandom_range(99);
		write_reg(REG_DEBOUNCE, (r < 20) ? 32'd0 : (r < 80) ? $urandom_range(100) :
			$urandom_range(65535));
		write_reg(REG_GAIN, $urandom_range(65535));
		write_reg(REG_DEADBAND, ($urandom_range(99) < 60) ? $urandom_range(2000) :
			$urandom_range(32767));
		write_reg(REG_VMAX, $urandom_range(32767));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset register values: a full flight, velocity edges, button debounce
	task automatic test_directed_defaults();
		idle_pct = 0;
		stall_pct = 0;
		offer_sample(mk_sample(0, 0, 0, 0, 0, 0, 1'b1, 32'd0));
		offer_sample(mk_sample(32767, 32767, 32767, -32768, 32767, -1, 1'b1, 32'd5));
		repeat (3) offer_sample(mk_sample(2048, 0, 0, 100, -200, 300, 1'b1, 32'd10));
		offer_sample(mk_sample(-32768, -32768, -32768, 1, 2, 3, 1'b1, 32'd20));
		offer_sample(mk_sample(0, 0, 0, 4, 5, 6, 1'b1, 32'd21));
		repeat (3) offer_sample(mk_sample(-32768, -32768, -32768, 7, 8, 9, 1'b1, 32'd22));
		// launch candidate just before the time counter wraps
		offer_sample(mk_sample(0, -2048, 0, 32767, -32768, -32768, 1'b1, 32'hFFFF_FFF0));
		offer_sample(mk_sample(2047, 0, 0, -5, 6, -7, 1'b1, 32'hFFFF_FFFA));
		offer_sample(mk_sample(0, 0, 0, -1, 32767, 1, 1'b1, 32'd5));
		offer_sample(mk_sample(0, 0, 0, 0, -32768, 0, 1'b1, 32'd6));
		offer_sample(mk_sample(0, 0, 0, 0, 273, 0, 1'b1, 32'd7));
		offer_sample(mk_sample(0, 0, 0, 0, 274, 0, 1'b1, 32'd8));
		offer_sample(mk_sample(0, 0, 0, 0, -274, 0, 1'b1, 32'd9));
		offer_sample(mk_sample(0, 0, 0, 0, 0, 0, 1'b1, 32'd10));
		// press too soon, press accepted, release too soon, release, press on the limit
		offer_sample(mk_sample(0, 0, 0, 0, 1000, 0, 1'b0, 32'd11));
		offer_sample(mk_sample(0, 0, 0, 0, 1000, 0, 1'b0, 32'd100));
		offer_sample(mk_sample(0, 0, 0, 0, 1000, 0, 1'b1, 32'd120));
		offer_sample(mk_sample(0, 0, 0, 0, 1000, 0, 1'b1, 32'd151));
		offer_sample(mk_sample(0, 0, 0, 0, 1000, 0, 1'b0, 32'd201));
	endtask

	// register extremes, zero confirm counts and exact rounding ties
	task automatic test_config_extremes();
		idle_pct = 35;
		stall_pct = 35;
		quiesce();
		write_reg(REG_AMBIENT_SQ, 32'd0);
		write_reg(REG_BURN_SQ, 32'd0);
		write_reg(REG_AMB_CONF, 32'hFFFF_FF00);
		write_reg(REG_BURN_CONF, 32'd0);
		write_reg(REG_DEBOUNCE, 32'd0);
		write_reg(REG_GAIN, 32'd4096);
		write_reg(REG_DEADBAND, 32'd0);
		write_reg(REG_VMAX, 32'h7FFF);
		write_reg(REG_NONE, 32'd5);
		// single still words confirm each phase; gain 16 gives ties at odd pitch
		repeat (3) offer_sample(mk_sample(0, 0, 0, 11, 1, 12, 1'b1, 32'd5000));
		offer_sample(mk_sample(0, 0, 0, 0, -1, 0, 1'b1, 32'd5001));
		offer_sample(mk_sample(0, 0, 0, 0, 3, 0, 1'b1, 32'd5002));
		offer_sample(mk_sample(0, 0, 0, 0, -3, 0, 1'b1, 32'd5003));
		quiesce();
		write_reg(REG_GAIN, 32'hFFFF);
		offer_sample(mk_sample(0, 0, 0, 0, 32767, 0, 1'b1, 32'd5004));
		offer_sample(mk_sample(0, 0, 0, 0, -32768, 0, 1'b1, 32'd5005));
		offer_sample(mk_sample(0, 0, 0, 0, 1, 0, 1'b1, 32'd5006));
		now_ms = 32'd6000;
		run_flights(30);

		// everything ambient, longest ambient run, dead velocity path
		quiesce();
		write_reg(REG_AMBIENT_SQ, THR_MAX);
		write_reg(REG_BURN_SQ, THR_MAX);
		write_reg(REG_AMB_CONF, 32'd255);
		write_reg(REG_BURN_CONF, 32'd1);
		write_reg(REG_DEBOUNCE, 32'hFFFF);
		write_reg(REG_GAIN, 32'd0);
		write_reg(REG_DEADBAND, 32'h7FFF);
		write_reg(REG_VMAX, 32'd0);
		bias_pct = 100;
		run_flights(560);

		// longest burn run under the reset thresholds
		quiesce();
		write_reg(REG_AMBIENT_SQ, 32'd5546967);
		write_reg(REG_BURN_SQ, 32'd16777216);
		write_reg(REG_AMB_CONF, 32'd1);
		write_reg(REG_BURN_CONF, 32'd255);
		write_reg(REG_DEBOUNCE, 32'd50);
		write_reg(REG_GAIN, 32'd512);
		write_reg(REG_DEADBAND, 32'd274);
		write_reg(REG_VMAX, 32'd20480);
		run_flights(290);
		bias_pct = 88;
	endtask

	// random settings and flights under each idling pattern
	task automatic test_random_flights();
		int idle_tbl[4];
		int stall_tbl[4];
		int p;
		idle_tbl = '{0, 46, 0, 35};
		stall_tbl = '{0, 0, 46, 35};
		for (p = 0; p < 4; p++) begin
			idle_pct = idle_tbl[p];
			stall_pct = stall_tbl[p];
			repeat (2) begin
				quiesce();
				shuffle_config();
				run_flights(110);
			end
		end
	endtask

	// receiver holds off for a long stretch while words keep coming
	task automatic test_backpressure();
		quiesce();
		idle_pct = 0;
		stall_pct = 0;
		hold_request = 300;
		run_flights(60);
	endtask

	initial begin
		cfg_shadow.ambient_threshold_sq = 32'd5546967;
		cfg_shadow.burn_threshold_sq = 32'd16777216;
		cfg_shadow.ambient_confirm = 8'd3;
		cfg_shadow.burn_confirm = 8'd3;
		cfg_shadow.debounce_ms = 16'd50;
		cfg_shadow.gain_q8 = 16'd512;
		cfg_shadow.deadband_counts = 15'd274;
		cfg_shadow.max_velocity_q8 = 15'd20480;
		ph = PH_AMBIENT;
		amb_cnt = '0;
		burn_cnt = '0;
		btn_prev = 1'b1;
		btn_time = '0;
		cand_time = '0;
		lat_time = '0;
		cand_ang = '0;
		lat_ang = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_config_extremes();
		test_random_flights();
		test_backpressure();
		quiesce();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/ldad_pkg.sv
src/launch_detect_attitude_drive.sv
test/tb.sv
